### src/edus_pkg.sv
// Shared types and constants of the edge-directed 2x upscaler.
// No dependencies; every other file refers to it by scoped names.
package edus_pkg;

  typedef logic [31:0] pix_t;
  typedef logic [3:0][31:0] line_t;

  // One emission request: centre, 20 rule neighbours and its tags.
  typedef struct packed {
    pix_t             c;
    logic [19:0][31:0] nb;
    logic [10:0]      cx;
    logic [10:0]      cy;
    logic             last;
  } job_t;

  // Neighbour order of the rule, as row and column offsets from the centre.
  localparam int NB_DY[20] = '{-2, -2, -2, -1, -1, -1, 0, 1, 0, 1,
                               2, 2, 2, 1, 1, 1, 0, -1, 0, -1};
  localparam int NB_DX[20] = '{-1, 0, 1, 0, 1, 2, 2, 2, 1, 1,
                               1, 0, -1, 0, -1, -2, -2, -2, -1, -1};

  // Folded luma/chroma weights of the colour distance.
  localparam int KR = 48 * 299 + 7 * (-169) + 6 * 500;
  localparam int KG = 48 * 587 + 7 * (-331) + 6 * (-419);
  localparam int KB = 48 * 114 + 7 * 500 + 6 * (-81);

  localparam int DW = 24;  // one distance
  localparam int SW = 27;  // one side of the edge test

  localparam int ODW = 56; // packed result data

  function automatic logic [DW-1:0] dist_f(input logic [7:0] ar, input logic [7:0] ag,
                                           input logic [7:0] ab);
    logic [31:0] s;
    s = 32'(KR) * 32'(ar) + 32'(KG) * 32'(ag) + 32'(KB) * 32'(ab);
    return s[DW-1:0];
  endfunction

endpackage

### src/edus_line_mem.sv
// Line store: one entry per source column holding four rows of RGBA.
// Synchronous, one write and one registered read port. Uses edus_pkg.
module edus_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output edus_pkg::line_t   rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  edus_pkg::line_t   wr_data_i
);

  edus_pkg::line_t mem_q [DEPTH];
  edus_pkg::line_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### src/edus_window.sv
// Column builder and 5x5 window: merges the line-store word with the new
// pixel, writes it back, shifts the window and issues emission requests. Uses edus_pkg.
module edus_window #(
  parameter int XW = 11,
  parameter int RW = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic [XW-1:0]   x_i,
  input  logic [RW-1:0]   r_i,
  input  edus_pkg::pix_t  px_i,
  input  logic            flush_i,
  input  logic            eor_i,
  output logic            ready_o,
  input  edus_pkg::line_t rd_data_i,
  output logic            wr_en_o,
  output logic [XW-1:0]   wr_addr_o,
  output edus_pkg::line_t wr_data_o,
  output logic            job_valid_o,
  output edus_pkg::job_t  job_o,
  input  logic            job_ready_i
);

  logic            s1_valid_q;
  logic [XW-1:0]   x_q;
  logic [RW-1:0]   r_q;
  edus_pkg::pix_t  px_q;
  logic            flush_q;
  logic            eor_q;
  logic [1:0]      step_q;
  logic            fwd_q;
  edus_pkg::line_t fwd_data_q;
  edus_pkg::pix_t  win_q [5][5];
  edus_pkg::pix_t  win_d [5][5];

  edus_pkg::line_t line;
  edus_pkg::pix_t  px_eff;
  edus_pkg::pix_t  col [5];
  logic            r_ge2;
  logic [1:0]      last_step;
  logic            emit;
  logic            advance;
  logic            done;
  logic [RW-1:0]   r_m1;
  logic [RW+2:0]   r_sum [5];
  logic [XW+11:0]  cx_ext;
  logic [RW+10:0]  cy_ext;

  always_comb begin
    line   = fwd_q ? fwd_data_q : rd_data_i;
    r_m1   = r_q - RW'(1);
    px_eff = (flush_q && (r_q != '0)) ? line[r_m1[1:0]] : px_q;
    for (int i = 0; i < 5; i++) begin
      r_sum[i] = (RW+3)'(r_q) + (RW+3)'(i);
      if (i == 4) begin
        col[i] = px_eff;
      end else if (r_sum[i] < (RW+3)'(4)) begin
        col[i] = (r_q == '0) ? px_eff : line[0];
      end else begin
        col[i] = line[r_sum[i][1:0]];
      end
    end
  end

  always_comb begin
    r_ge2     = (r_q >= RW'(2));
    last_step = (eor_q && r_ge2) ? 2'd2 : 2'd0;
    case (step_q)
      2'd0:    emit = r_ge2 && ((XW+1)'(x_q) >= (XW+1)'(2));
      2'd1:    emit = (x_q != '0);
      default: emit = 1'b1;
    endcase
    advance = s1_valid_q && (!emit || job_ready_i);
    done    = advance && (step_q == last_step);
    ready_o = !s1_valid_q || done;
  end

  // Reload the whole window at the left edge, otherwise shift in one column.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        if (step_q == 2'd0 && x_q == '0) begin
          win_d[i][j] = col[i];
        end else if (j == 4) begin
          win_d[i][j] = col[i];
        end else begin
          win_d[i][j] = win_q[i][j+1];
        end
      end
    end
  end

  always_comb begin
    wr_en_o   = done;
    wr_addr_o = x_q;
    wr_data_o = line;
    wr_data_o[r_q[1:0]] = px_eff;
  end

  always_comb begin
    cx_ext      = (XW+12)'(x_q) + (XW+12)'(step_q) - (XW+12)'(2);
    cy_ext      = (RW+11)'(r_q) - (RW+11)'(2);
    job_o.c     = win_d[2][2];
    for (int i = 0; i < 20; i++) begin
      job_o.nb[i] = win_d[2 + edus_pkg::NB_DY[i]][2 + edus_pkg::NB_DX[i]];
    end
    job_o.cx    = cx_ext[10:0];
    job_o.cy    = cy_ext[10:0];
    job_o.last  = (step_q == last_step);
    job_valid_o = s1_valid_q && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      step_q     <= 2'd0;
      fwd_q      <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
        step_q     <= 2'd0;
        fwd_q      <= done && (wr_addr_o == x_i);
      end else if (done) begin
        s1_valid_q <= 1'b0;
      end else if (advance) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      x_q        <= x_i;
      r_q        <= r_i;
      px_q       <= px_i;
      flush_q    <= flush_i;
      eor_q      <= eor_i;
      fwd_data_q <= wr_data_o;
    end
    if (advance) begin
      win_q <= win_d;
    end
  end

  a_wr_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> s1_valid_q)
    else $error("line write without an item in the column stage");
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> (!s1_valid_q || done))
    else $error("new request overwrote a busy column stage");
  a_job_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> r_ge2)
    else $error("emission requested in the top two rows");
  a_fwd_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(wr_en_o))
    else $error("forwarding armed without a colliding write");

endmodule

### src/edus_rule.sv
// Edge rule unit: one rotation per cycle while the output is not stalled, through
// select, abs-diff, distance and compare/blend to the result register. Uses edus_pkg.
module edus_rule (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  edus_pkg::job_t                job_i,
  output logic                          job_ready_o,
  output logic                          out_valid_o,
  output logic [edus_pkg::ODW-1:0]      out_data_o,
  output logic                          out_last_o,
  input  logic                          out_ready_i
);

  edus_pkg::job_t job_q;
  logic           job_valid_q;
  logic [1:0]     rot_q;
  logic           en;
  logic           issue;

  edus_pkg::pix_t p [20];
  edus_pkg::pix_t pa [12];
  edus_pkg::pix_t pb [12];

  logic           vb_q;
  logic [7:0]     ad_q [12][3];
  edus_pkg::pix_t cb_q, n18b_q, n3b_q;
  logic [10:0]    cxb_q, cyb_q;
  logic [1:0]     rotb_q;
  logic           lastb_q;

  logic                  vc_q;
  logic [edus_pkg::DW-1:0] d_q [12];
  edus_pkg::pix_t        cc_q, n18c_q, n3c_q;
  logic [10:0]           cxc_q, cyc_q;
  logic [1:0]            rotc_q;
  logic                  lastc_q;

  logic                  out_valid_q;
  logic [edus_pkg::ODW-1:0] out_data_q;
  logic                  out_last_q;

  logic [edus_pkg::SW-1:0] lhs, rhs;
  edus_pkg::pix_t        nc, t;
  logic [8:0]            hs [3];

  assign en          = !out_valid_q || out_ready_i;
  assign issue       = job_valid_q && en;
  assign job_ready_o = !job_valid_q || (en && rot_q == 2'd3);

  // Rotate the neighbour ring by five places per quarter turn.
  always_comb begin
    case (rot_q)
      2'd0: for (int i = 0; i < 20; i++) p[i] = job_q.nb[i];
      2'd1: for (int i = 0; i < 20; i++) p[i] = job_q.nb[(i + 5) % 20];
      2'd2: for (int i = 0; i < 20; i++) p[i] = job_q.nb[(i + 10) % 20];
      default: for (int i = 0; i < 20; i++) p[i] = job_q.nb[(i + 15) % 20];
    endcase
    pa[0] = job_q.c; pb[0] = p[14];
    pa[1] = job_q.c; pb[1] = p[4];
    pa[2] = p[19];   pb[2] = p[16];
    pa[3] = p[19];   pb[3] = p[1];
    pa[4] = p[18];   pb[4] = p[3];
    pa[5] = p[18];   pb[5] = p[13];
    pa[6] = p[18];   pb[6] = p[17];
    pa[7] = p[3];    pb[7] = p[8];
    pa[8] = p[3];    pb[8] = p[0];
    pa[9] = job_q.c; pb[9] = p[19];
    pa[10] = job_q.c; pb[10] = p[18];
    pa[11] = job_q.c; pb[11] = p[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      rot_q       <= 2'd0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_ready_o) begin
        job_valid_q <= job_valid_i;
        rot_q       <= 2'd0;
      end else if (issue) begin
        rot_q <= rot_q + 2'd1;
      end
      if (en) begin
        vb_q        <= issue;
        vc_q        <= vb_q;
        out_valid_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_ready_o && job_valid_i) begin
      job_q <= job_i;
    end
    if (en) begin
      for (int j = 0; j < 12; j++) begin
        for (int k = 0; k < 3; k++) begin
          ad_q[j][k] <= (pa[j][8*k +: 8] > pb[j][8*k +: 8]) ?
                        pa[j][8*k +: 8] - pb[j][8*k +: 8] :
                        pb[j][8*k +: 8] - pa[j][8*k +: 8];
        end
      end
      cb_q    <= job_q.c;
      n18b_q  <= p[18];
      n3b_q   <= p[3];
      cxb_q   <= job_q.cx;
      cyb_q   <= job_q.cy;
      rotb_q  <= rot_q;
      lastb_q <= job_q.last && (rot_q == 2'd3);

      for (int j = 0; j < 12; j++) begin
        d_q[j] <= edus_pkg::dist_f(ad_q[j][0], ad_q[j][1], ad_q[j][2]);
      end
      cc_q    <= cb_q;
      n18c_q  <= n18b_q;
      n3c_q   <= n3b_q;
      cxc_q   <= cxb_q;
      cyc_q   <= cyb_q;
      rotc_q  <= rotb_q;
      lastc_q <= lastb_q;

      out_data_q <= {rotc_q[1], rotc_q[1] ^ rotc_q[0], cyc_q, cxc_q, t};
      out_last_q <= lastc_q;
    end
  end

  always_comb begin
    lhs = edus_pkg::SW'(d_q[0]) + edus_pkg::SW'(d_q[1]) + edus_pkg::SW'(d_q[2])
        + edus_pkg::SW'(d_q[3]) + (edus_pkg::SW'(d_q[4]) << 2);
    rhs = edus_pkg::SW'(d_q[5]) + edus_pkg::SW'(d_q[6]) + edus_pkg::SW'(d_q[7])
        + edus_pkg::SW'(d_q[8]) + (edus_pkg::SW'(d_q[9]) << 2);
    nc  = (d_q[10] <= d_q[11]) ? n18c_q : n3c_q;
    for (int k = 0; k < 3; k++) begin
      hs[k] = 9'(nc[8*k +: 8]) + 9'(cc_q[8*k +: 8]);
    end
    if (lhs < rhs) begin
      t = {cc_q[31:24], hs[2][8:1], hs[1][8:1], hs[0][8:1]};
    end else begin
      t = cc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

### src/edge_directed_2x_upscaler.sv
// Top level of the edge-directed 2x upscaler: stream ports, width register,
// raster counters, line store, window stage and rule unit. Uses edus_pkg.
//
//  channel  | dir | payload (lsb first)                                 | side info
//  ---------+-----+-----------------------------------------------------+------------------
//  s_axis   | in  | tdata: pix_r, pix_g, pix_b, pix_a (32 bits)         | tuser: mode
//  m_axis   | out | tdata: out_r, out_g, out_b, out_a, center_x,        | tlast: last_of_run
//           |     |        center_y, sub_col, sub_row (56 bits)         |
//  cfg      | in  | cfg_wdata_i: image_width (12 bits), write on we     |
//
// Flow: the line store is read at the accepting edge; the request then passes through
// its window steps: one step, or three on a row-ending item of an output row. Each
// emitting step hands one centre to the rule unit, which evaluates one rotation per
// cycle while its output is not stalled and takes the next centre only as it issues
// the last rotation of the current one. Results leave from the result register.
// Reset: counters clear and the width register returns to 2048; the line store
// is not cleared, entries are written before they are read in a valid stream.
// Stalls: the result register holds while m_axis_tready is low; the rule unit
// and window stage back up behind it, and s_axis_tready drops once the window
// stage cannot finish its current request.
module edge_directed_2x_upscaler #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,     // image_width
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // pix_r, pix_g, pix_b, pix_a
  input  logic        s_axis_tuser,    // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,    // out_r, out_g, out_b, out_a, center_x, center_y,
                                       // sub_col, sub_row
  output logic        m_axis_tlast     // last_of_run
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int EW = (XW + 1 > 13) ? XW + 1 : 13;

  logic [11:0]   image_width_q;
  logic [XW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          flush_rows_q, flush_rows_d;

  logic [EW-1:0] w_eff, col_ext, x_ext;
  logic [XW-1:0] x;
  logic          eor;
  logic          acc;
  logic          win_ready;
  logic [RW-1:0] row_inc;

  edus_pkg::line_t rd_data;
  logic            wr_en;
  logic [XW-1:0]   wr_addr;
  edus_pkg::line_t wr_data;
  logic            job_valid;
  edus_pkg::job_t  job;
  logic            job_ready;

  // Clamp the programmed width into 1..MAX_WIDTH, then clamp the column to it.
  always_comb begin
    if (image_width_q == '0) begin
      w_eff = EW'(1);
    end else if (EW'(image_width_q) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width_q);
    end
    col_ext = EW'(col_q);
    x_ext   = (col_ext >= w_eff) ? w_eff - EW'(1) : col_ext;
    x       = x_ext[XW-1:0];
    eor     = (x_ext == w_eff - EW'(1));
  end

  assign s_axis_tready = win_ready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Advance the raster position; two flush rows in a row end the frame.
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    flush_rows_d = flush_rows_q;
    row_inc      = (row_q < RW'(MAX_HEIGHT + 1)) ? row_q + RW'(1) : row_q;
    if (acc) begin
      if (eor) begin
        col_d = '0;
        if (s_axis_tuser) begin
          if (flush_rows_q) begin
            flush_rows_d = 1'b0;
            row_d        = '0;
          end else begin
            flush_rows_d = 1'b1;
            row_d        = row_inc;
          end
        end else begin
          flush_rows_d = 1'b0;
          row_d        = row_inc;
        end
      end else begin
        col_d = x + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= 12'd2048;
      col_q         <= '0;
      row_q         <= '0;
      flush_rows_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        image_width_q <= cfg_wdata_i;
      end
      col_q        <= col_d;
      row_q        <= row_d;
      flush_rows_q <= flush_rows_d;
    end
  end

  edus_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (x),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  edus_window #(
    .XW (XW),
    .RW (RW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .x_i         (x),
    .r_i         (row_q),
    .px_i        (s_axis_tdata),
    .flush_i     (s_axis_tuser),
    .eor_i       (eor),
    .ready_o     (win_ready),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  edus_rule u_rule (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ready_i (m_axis_tready)
  );

endmodule
